// ===== rtl/apc_pkg.sv =====
// shared types, constants and saturation helpers for the actuator position controller
// no dependencies
package apc_pkg;

  localparam int PosWidth = 16;
  localparam int SumW     = PosWidth + 18;
  localparam int ErrW     = PosWidth + 1;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [7:0]  MinSpeedRst     = 8'd96;
  localparam logic [14:0] MaxPositionRst  = 15'd2250;
  localparam logic [15:0] TimeoutTicksRst = 16'd5000;
  localparam logic [7:0]  PhantomTicksRst = 8'd4;

  localparam int FlagLimitEdge = 0;
  localparam int FlagLimitStop = 1;
  localparam int FlagMotorStop = 2;
  localparam int FlagTimeout   = 3;
  localparam int FlagPhantom   = 4;
  localparam int FlagDirty     = 5;

  localparam logic signed [SumW-1:0] PosHi = SumW'((64'sd1 <<< (PosWidth - 1)) - 64'sd1);
  localparam logic signed [SumW-1:0] PosLo = -PosHi - SumW'(1);
  localparam logic signed [SumW-1:0] Hi16  = SumW'(32767);
  localparam logic signed [SumW-1:0] Lo16  = -Hi16 - SumW'(1);

  typedef enum logic [1:0] {
    KindTick  = 2'd0,
    KindMove  = 2'd1,
    KindLimit = 2'd2
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMinSpeed     = 2'd0,
    CfgMaxPosition  = 2'd1,
    CfgTimeoutTicks = 2'd2,
    CfgPhantomTicks = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        pulse_count;
    logic               limit_level;
    logic signed [15:0] goal;
  } in_item_t;

  typedef struct packed {
    logic signed [8:0]  drive;
    logic signed [15:0] position;
    logic signed [15:0] target;
    logic [5:0]         flags;
    logic signed [15:0] open_error;
    logic               clear_counter;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  speed_floor;
    logic [14:0] max_position;
    logic [15:0] timeout_ticks;
    logic [7:0]  phantom_ticks;
  } cfg_t;

  typedef struct packed {
    logic signed [PosWidth-1:0] pos;
    logic signed [PosWidth-1:0] target;
    logic signed [8:0]          speed;
    logic                       dir_fwd;
    logic [15:0]                last_count;
    logic [15:0]                pulse_age;
    logic [10:0]                ramp;
    logic [5:0]                 flags;
    logic signed [15:0]         open_err;
  } state_t;

  function automatic logic signed [PosWidth-1:0] sat_pos(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = v;
    if (v > PosHi) begin
      r = PosHi;
    end else if (v < PosLo) begin
      r = PosLo;
    end
    return r[PosWidth-1:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    r = v;
    if (v > Hi16) begin
      r = Hi16;
    end else if (v < Lo16) begin
      r = Lo16;
    end
    return r[15:0];
  endfunction

endpackage

// ===== rtl/apc_cfg.sv =====
// configuration register file of the actuator position controller
// depends on apc_pkg
module apc_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [apc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output apc_pkg::cfg_t                cfg_o
);
  import apc_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgMinSpeed:     cfg_d.speed_floor   = cfg_wdata_i[7:0];
        CfgMaxPosition:  cfg_d.max_position  = cfg_wdata_i[14:0];
        CfgTimeoutTicks: cfg_d.timeout_ticks = cfg_wdata_i[15:0];
        CfgPhantomTicks: cfg_d.phantom_ticks = cfg_wdata_i[7:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_floor   <= MinSpeedRst;
      cfg_q.max_position  <= MaxPositionRst;
      cfg_q.timeout_ticks <= TimeoutTicksRst;
      cfg_q.phantom_ticks <= PhantomTicksRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/apc_update.sv =====
// next-state logic for one tick, move command or limit edge
// depends on apc_pkg
module apc_update (
  input  apc_pkg::state_t   st_i,
  input  apc_pkg::cfg_t     cfg_i,
  input  apc_pkg::in_item_t item_i,
  output apc_pkg::state_t   st_o,
  output logic              clear_o
);
  import apc_pkg::*;

  state_t                 s;
  logic                   clr;
  logic [15:0]            delta;
  logic signed [SumW-1:0] pos_x;
  logic signed [SumW-1:0] delta_x;
  logic signed [SumW-1:0] goal_x;
  logic signed [ErrW-1:0] err;
  logic signed [ErrW-1:0] ms_neg;
  logic [ErrW-1:0]        err_abs;
  logic [7:0]             mag;
  logic [7:0]             ramp8;
  logic                   zero_lim;
  logic                   err_neg;

  always_comb begin
    s        = st_i;
    clr      = 1'b0;
    delta    = item_i.pulse_count - st_i.last_count;
    delta_x  = SumW'(signed'({1'b0, delta}));
    goal_x   = SumW'(item_i.goal);
    pos_x    = '0;
    err      = '0;
    ms_neg   = -ErrW'(signed'({1'b0, cfg_i.speed_floor}));
    err_abs  = '0;
    mag      = '0;
    ramp8    = '0;
    zero_lim = 1'b0;
    err_neg  = 1'b0;
    case (item_i.kind)
      KindTick: begin
        if (s.pulse_age != 16'hffff) begin
          s.pulse_age = s.pulse_age + 16'd1;
        end
        if (s.ramp != 11'h7ff) begin
          s.ramp = s.ramp + 11'd1;
        end
        if (delta == 16'd0) begin
          if (s.pulse_age > cfg_i.timeout_ticks && s.speed != 9'sd0) begin
            s.speed                 = '0;
            clr                     = 1'b1;
            s.last_count            = '0;
            s.target                = s.pos;
            s.flags[FlagTimeout]    = 1'b1;
            s.flags[FlagMotorStop]  = 1'b1;
          end
        end else begin
          if (s.pulse_age < {8'd0, cfg_i.phantom_ticks}) begin
            s.flags[FlagPhantom] = 1'b1;
          end else begin
            pos_x              = SumW'(s.pos);
            s.pos              = sat_pos(s.dir_fwd ? pos_x + delta_x : pos_x - delta_x);
            s.flags[FlagDirty] = 1'b1;
          end
          s.last_count = item_i.pulse_count;
          s.pulse_age  = '0;
        end

        err = ErrW'(s.target) - ErrW'(s.pos);
        if (item_i.limit_level) begin
          if (!(s.target > 0 && !err[ErrW-1])) begin
            zero_lim = 1'b1;
          end
        end else if (s.target == '0) begin
          if (!((s.speed < 0 && err < 0) || (s.speed == 0 && err > 0) ||
                (s.speed > 0 && err < 0))) begin
            err = ms_neg;
          end
        end else if (s.target < 0) begin
          if (!err[ErrW-1]) begin
            err = ms_neg;
          end
        end

        if (zero_lim) begin
          s.open_err             = sat16(SumW'(s.pos));
          s.pos                  = '0;
          s.speed                = '0;
          clr                    = 1'b1;
          s.last_count           = '0;
          s.target               = '0;
          s.flags[FlagLimitStop] = 1'b1;
        end else begin
          err_neg = err[ErrW-1];
          err_abs = err_neg ? -err : err;
          mag     = (err_abs > ErrW'(127)) ? 8'd255 : {err_abs[6:0], 1'b0};
          ramp8   = s.ramp[10:3];
          if (ramp8 < mag) begin
            mag = ramp8;
          end
          if (mag < cfg_i.speed_floor) begin
            mag = cfg_i.speed_floor;
          end
          if (err == '0) begin
            s.speed = '0;
          end else begin
            s.speed = err_neg ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
            if (mag != 8'd0) begin
              s.dir_fwd = !err_neg;
            end
          end
        end
      end
      KindMove: begin
        s.flags = '0;
        if (item_i.goal > signed'({1'b0, cfg_i.max_position})) begin
          s.flags = '0;
        end else if ((item_i.goal[15] || item_i.goal == 16'sd0) && item_i.limit_level) begin
          s.pos    = '0;
          s.target = '0;
        end else begin
          s.target    = sat_pos(goal_x);
          s.pulse_age = '0;
          s.ramp      = '0;
        end
      end
      KindLimit: begin
        if (s.speed < 0) begin
          s.open_err             = sat16(SumW'(s.pos));
          s.pos                  = '0;
          s.speed                = '0;
          clr                    = 1'b1;
          s.last_count           = '0;
          s.target               = '0;
          s.flags[FlagLimitEdge] = 1'b1;
        end
      end
      default: begin
        s = st_i;
      end
    endcase
    st_o    = s;
    clear_o = clr;
  end

endmodule

// ===== rtl/actuator_position_controller.sv =====
// actuator position controller: input register, next-state logic, result register
// an item waits in the input register while the result register is stalled, then its result is registered there
// throughput: one item per cycle, a transfer each cycle while the output is not stalled
// reset: state cleared, direction forward, registers at their defaults, both stages empty
// depends on apc_pkg, apc_cfg and apc_update
module actuator_position_controller (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  apc_pkg::in_item_t            in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output apc_pkg::out_item_t           out_data_o,
  input  logic                         cfg_we_i,
  input  logic [apc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [apc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import apc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  state_t    st_q;
  state_t    st_d;
  logic      clear;
  out_item_t out_q;
  out_item_t out_d;
  logic      out_valid_q;
  logic      out_free;
  logic      advance;
  logic      take_in;
  logic signed [SumW-1:0] pos_w;
  logic signed [SumW-1:0] tgt_w;

  apc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  apc_update u_update (
    .st_i   (st_q),
    .cfg_i  (cfg),
    .item_i (in_q),
    .st_o   (st_d),
    .clear_o(clear)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign take_in    = in_valid_i && !in_stall_o;

  assign pos_w = SumW'(st_d.pos);
  assign tgt_w = SumW'(st_d.target);

  always_comb begin
    out_d.drive         = st_d.speed;
    out_d.position      = pos_w[15:0];
    out_d.target        = tgt_w[15:0];
    out_d.flags         = st_d.flags;
    out_d.open_error    = st_d.open_err;
    out_d.clear_counter = clear;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= '{dir_fwd: 1'b1, default: '0};
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        st_q        <= st_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed item produced no result");

  a_drive_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.drive != -9'sd256)
    else $error("drive out of range");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with free pipeline");
`endif

endmodule

// ===== tb/actuator_position_controller_tb.sv =====
// self-checking testbench for the actuator position controller: a directed table, then random
// ticks, moves and limit edges under several register settings, checked against a predictor
// depends on apc_pkg and the actuator_position_controller rtl
`timescale 1ns / 100ps

module actuator_position_controller_tb;
  import apc_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 325;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } plan_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  in_item_t           in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  out_item_t          out_data_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  out_item_t expected_reports[$];
  plan_row_t directed_plan[$];
  int        mismatches = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic [15:0] enc_count = '0;

  // controller state as tracked by the predictor
  cfg_t        ctl_cfg;
  longint      ctl_pos, ctl_target, ctl_speed, ctl_open_err;
  bit          ctl_fwd;
  logic [15:0] ctl_last;
  int unsigned ctl_age, ctl_ramp;
  logic [5:0]  ctl_flags;
  bit          ctl_clear;

  actuator_position_controller u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint clip_signed(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void reset_controller();
    ctl_cfg = '{speed_floor: MinSpeedRst, max_position: MaxPositionRst,
                timeout_ticks: TimeoutTicksRst, phantom_ticks: PhantomTicksRst};
    ctl_pos = 0;
    ctl_target = 0;
    ctl_speed = 0;
    ctl_open_err = 0;
    ctl_fwd = 1'b1;
    ctl_last = '0;
    ctl_age = 0;
    ctl_ramp = 0;
    ctl_flags = '0;
    ctl_clear = 1'b0;
  endfunction

  function automatic void halt_motor();
    ctl_speed = 0;
    ctl_clear = 1'b1;
    ctl_last = '0;
    ctl_target = ctl_pos;
  endfunction

  function automatic void zero_at_limit();
    ctl_open_err = clip_signed(ctl_pos, 16);
    ctl_pos = 0;
    halt_motor();
  endfunction

  function automatic void ctl_tick(input logic [15:0] cnt, input bit lim);
    logic [15:0] delta;
    longint step, err, ns, ramp8, ms;
    delta = cnt - ctl_last;
    step = delta;
    ms = ctl_cfg.speed_floor;
    ns = 0;
    if (ctl_age < 65535) ctl_age++;
    if (ctl_ramp < 2047) ctl_ramp++;
    if (delta == 0) begin
      if (ctl_age > ctl_cfg.timeout_ticks && ctl_speed != 0) begin
        halt_motor();
        ctl_flags[FlagTimeout] = 1'b1;
        ctl_flags[FlagMotorStop] = 1'b1;
      end
    end else begin
      if (ctl_age < ctl_cfg.phantom_ticks) begin
        ctl_flags[FlagPhantom] = 1'b1;
      end else begin
        ctl_pos = clip_signed(ctl_fwd ? ctl_pos + step : ctl_pos - step, PosWidth);
        ctl_flags[FlagDirty] = 1'b1;
      end
      ctl_last = cnt;
      ctl_age = 0;
    end
    err = ctl_target - ctl_pos;
    if (lim) begin
      if (!(ctl_target > 0 && err >= 0)) begin
        zero_at_limit();
        ctl_flags[FlagLimitStop] = 1'b1;
        return;
      end
    end else if (ctl_target == 0) begin
      if (!((ctl_speed < 0 && err < 0) || (ctl_speed == 0 && err > 0) ||
            (ctl_speed > 0 && err < 0))) err = -ms;
    end else if (ctl_target < 0) begin
      if (err >= 0) err = -ms;
    end
    ramp8 = ctl_ramp / 8;
    if (err > 0) begin
      ns = (2 * err > 255) ? 255 : 2 * err;
      if (ramp8 < ns) ns = ramp8;
      if (ns < ms) ns = ms;
    end else if (err < 0) begin
      ns = (2 * err < -255) ? -255 : 2 * err;
      if (ns < -ramp8) ns = -ramp8;
      if (ns > -ms) ns = -ms;
    end
    ctl_speed = ns;
    if (ns > 0) ctl_fwd = 1'b1;
    else if (ns < 0) ctl_fwd = 1'b0;
  endfunction

  function automatic void ctl_move(input logic signed [15:0] goal, input bit lim);
    longint g;
    longint top;
    g = goal;
    top = ctl_cfg.max_position;
    ctl_flags = '0;
    if (g > top) return;
    if (g <= 0 && lim) begin
      ctl_pos = 0;
      ctl_target = 0;
      return;
    end
    ctl_target = clip_signed(g, PosWidth);
    ctl_age = 0;
    ctl_ramp = 0;
  endfunction

  function automatic out_item_t advance_controller(input in_item_t it);
    out_item_t r;
    ctl_clear = 1'b0;
    case (it.kind)
      KindTick: ctl_tick(it.pulse_count, it.limit_level);
      KindMove: ctl_move(it.goal, it.limit_level);
      KindLimit: begin
        if (ctl_speed < 0) begin
          zero_at_limit();
          ctl_flags[FlagLimitEdge] = 1'b1;
        end
      end
      default: ;
    endcase
    r.drive = ctl_speed[8:0];
    r.position = ctl_pos[15:0];
    r.target = ctl_target[15:0];
    r.flags = ctl_flags;
    r.open_error = ctl_open_err[15:0];
    r.clear_counter = ctl_clear;
    return r;
  endfunction

  function automatic void plan_row(input logic [1:0] kind, input logic [15:0] cnt,
                                   input bit lim, input logic signed [15:0] goal,
                                   input bit typed = 1'b0, input out_item_t want = '0);
    plan_row_t row;
    row.item = '{kind: kind, pulse_count: cnt, limit_level: lim, goal: goal};
    row.typed = typed;
    row.want = want;
    directed_plan.push_back(row);
  endfunction

  // mostly encoder-consistent ticks and reachable moves, with some noise
  function automatic in_item_t make_item();
    in_item_t it;
    int roll;
    longint g;
    it.kind = KindTick;
    it.pulse_count = 16'($urandom);
    it.limit_level = ($urandom_range(99) < 8);
    it.goal = 16'($urandom);
    roll = $urandom_range(99);
    if (roll < 68) begin
      it.pulse_count = enc_count;
      if ($urandom_range(1) == 1) begin
        it.pulse_count = enc_count + (($urandom_range(19) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(12, 1)));
      end
    end else if (roll < 82) begin
      it.kind = KindMove;
      case ($urandom_range(3))
        0: g = longint'($urandom_range(ctl_cfg.max_position));
        1: g = ctl_pos + longint'($urandom_range(160)) - 80;
        2: g = -longint'($urandom_range(300));
        default: g = longint'($signed(16'($urandom)));
      endcase
      it.goal = 16'(clip_signed(g, 16));
      it.limit_level = ($urandom_range(99) < 20);
    end else if (roll < 92) begin
      it.kind = KindLimit;
    end else if (roll < 95) begin
      it.kind = KindUnused;
    end else begin
      it.kind = 2'($urandom_range(3));
    end
    return it;
  endfunction

  function automatic void compare_field(input string name, input longint want,
                                        input longint got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_item(input in_item_t it, output out_item_t pred);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(2, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = advance_controller(it);
    items_sent++;
    if (pred.clear_counter) enc_count = '0;
    else if (it.kind == KindTick) enc_count = it.pulse_count;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_settings(input cfg_t s);
    cfg_index_e idx;
    logic [CfgDataW-1:0] val;
    for (int i = 0; i < 4; i++) begin
      idx = cfg_index_e'(i);
      case (idx)
        CfgMinSpeed:    val = CfgDataW'(s.speed_floor);
        CfgMaxPosition: val = CfgDataW'(s.max_position);
        CfgTimeoutTicks: val = s.timeout_ticks;
        default:        val = CfgDataW'(s.phantom_ticks);
      endcase
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_wdata_i <= val;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    ctl_cfg = s;
  endtask

  always @(posedge clk_i) begin : result_monitor
    out_item_t want;
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $display("%0t result with nothing expected: %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        compare_field("drive", want.drive, out_data_o.drive);
        compare_field("position", want.position, out_data_o.position);
        compare_field("target", want.target, out_data_o.target);
        compare_field("flags", want.flags, out_data_o.flags);
        compare_field("open_error", want.open_error, out_data_o.open_error);
        compare_field("clear_counter", want.clear_counter, out_data_o.clear_counter);
        results_seen++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_reports.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cfg_t      settings[6];
    out_item_t pred;
    reset_controller();

    plan_row(KindUnused, 16'h0000, 1'b0, 16'sh0000, 1'b1, '0);
    plan_row(KindMove, 16'h0000, 1'b0, 16'sh7fff, 1'b1, '0);
    plan_row(KindMove, 16'h0000, 1'b1, 16'sh8000, 1'b1, '0);
    plan_row(KindLimit, 16'h0000, 1'b0, 16'sh0000, 1'b1, '0);
    plan_row(KindMove, 16'h0000, 1'b0, 16'sd100, 1'b1,
             '{drive: 9'sd0, position: 16'sd0, target: 16'sd100, flags: 6'd0,
               open_error: 16'sd0, clear_counter: 1'b0});
    plan_row(KindTick, 16'h0000, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'h000a, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'h000a, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'h000a, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'h000a, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'h000a, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'h001e, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'hffff, 1'b0, 16'sh0000);
    plan_row(KindMove, 16'h0000, 1'b0, 16'sd2250);
    plan_row(KindTick, 16'hffff, 1'b0, 16'sh0000);
    plan_row(KindMove, 16'h0000, 1'b0, -16'sd5);
    plan_row(KindTick, 16'h0000, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'h0000, 1'b1, 16'sh0000);
    plan_row(KindMove, 16'h0000, 1'b0, 16'sh8000);
    plan_row(KindTick, 16'h0000, 1'b0, 16'sh0000);
    plan_row(KindLimit, 16'h0000, 1'b0, 16'sh0000);
    plan_row(KindMove, 16'h0000, 1'b0, 16'sh0000);
    plan_row(KindTick, 16'h0064, 1'b0, 16'sh0000);
    plan_row(KindUnused, 16'hffff, 1'b1, 16'sh8000);

    settings[0] = '{speed_floor: 8'd96, max_position: 15'd2250, timeout_ticks: 16'd5000,
                    phantom_ticks: 8'd4};
    settings[1] = '{speed_floor: 8'd0, max_position: 15'd0, timeout_ticks: 16'd1,
                    phantom_ticks: 8'd0};
    settings[2] = '{speed_floor: 8'd255, max_position: 15'd32767, timeout_ticks: 16'd65535,
                    phantom_ticks: 8'd255};
    settings[3] = '{speed_floor: 8'($urandom_range(255)),
                    max_position: 15'($urandom_range(32767)),
                    timeout_ticks: 16'($urandom_range(64, 1)),
                    phantom_ticks: 8'($urandom_range(8))};
    settings[4] = '{speed_floor: 8'd40, max_position: 15'd600, timeout_ticks: 16'd3,
                    phantom_ticks: 8'd2};
    settings[5] = '{speed_floor: 8'd1, max_position: 15'd32767, timeout_ticks: 16'd12,
                    phantom_ticks: 8'd1};

    send_idle_pct = 25;
    recv_stall_pct = 48;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      send_item(directed_plan[i].item, pred);
      expected_reports.push_back(directed_plan[i].typed ? directed_plan[i].want : pred);
    end

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 25 : (p < 4) ? 48 : 0;
      recv_stall_pct = (p < 2) ? 48 : (p < 4) ? 25 : 0;
      wait_for_results();
      load_settings(settings[p]);
      repeat (PhaseItems) begin
        send_item(make_item(), pred);
        expected_reports.push_back(pred);
      end
    end

    wait_for_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d transfers in over six register settings with both sides idling",
             items_sent);
    $display("%0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
